// File: rtl/clsc_pkg.sv
// clsc_pkg: shared types, codes and byte tables of the command-line colorizer
`default_nettype none
package clsc_pkg;

    localparam int LINE_LENGTH_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int IDX_W           = 4;

    typedef enum logic [1:0] {
        OP_CHAR    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_BACKERR = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        M_PLAIN  = 3'd0,
        M_DASH1  = 3'd1,
        M_OPT    = 3'd2,
        M_DASH2  = 3'd3,
        M_TOKEN  = 3'd4,
        M_STRING = 3'd5,
        M_DOLLAR = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        PRE_NONE = 3'd0,
        PRE_ERR  = 3'd1,
        PRE_MAG  = 3'd2,
        PRE_CYN  = 3'd3,
        PRE_YEL  = 3'd4,
        PRE_RST  = 3'd5
    } pre_t;

    typedef enum logic [1:0] {
        BODY_NONE  = 2'd0,
        BODY_CHAR  = 2'd1,
        BODY_DOT   = 2'd2,
        BODY_ARROW = 2'd3
    } body_t;

    typedef enum logic [1:0] {
        SEG_PRE  = 2'd0,
        SEG_BODY = 2'd1,
        SEG_SUF  = 2'd2
    } seg_t;

    // one output sequence: optional escape, optional body, optional reset escape
    typedef struct packed {
        pre_t       pre;
        body_t      body;
        logic       suf_rst;
        logic [7:0] ch;
    } job_t;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [IDX_W-1:0] pre_len(input pre_t p);
        logic [IDX_W-1:0] n;
        unique case (p)
            PRE_ERR:                   n = 4'd10;
            PRE_MAG, PRE_CYN, PRE_YEL: n = 4'd7;
            PRE_RST:                   n = 4'd4;
            default:                   n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [IDX_W-1:0] body_len(input body_t b);
        logic [IDX_W-1:0] n;
        unique case (b)
            BODY_CHAR:  n = 4'd1;
            BODY_DOT:   n = 4'd2;
            BODY_ARROW: n = 4'd3;
            default:    n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] rst_byte(input logic [IDX_W-1:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = CH_ESC;
            4'd1:    b = 8'h5B;
            4'd2:    b = 8'h30;
            default: b = 8'h6D;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] err_byte(input logic [IDX_W-1:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = CH_ESC;
            4'd1:    b = 8'h5B;
            4'd2:    b = 8'h31;
            4'd3:    b = 8'h3B;
            4'd4:    b = 8'h33;
            4'd5:    b = 8'h37;
            4'd6:    b = 8'h3B;
            4'd7:    b = 8'h34;
            4'd8:    b = 8'h31;
            default: b = 8'h6D;
        endcase
        return b;
    endfunction

    // bold color escape, digit selects the color
    function automatic logic [7:0] color_byte(input logic [IDX_W-1:0] i,
                                              input logic [7:0] digit);
        logic [7:0] b;
        case (i)
            4'd0:    b = CH_ESC;
            4'd1:    b = 8'h5B;
            4'd2:    b = 8'h31;
            4'd3:    b = 8'h3B;
            4'd4:    b = 8'h33;
            4'd5:    b = digit;
            default: b = 8'h6D;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pre_byte(input pre_t p, input logic [IDX_W-1:0] i);
        logic [7:0] b;
        unique case (p)
            PRE_ERR: b = err_byte(i);
            PRE_MAG: b = color_byte(i, 8'h35);
            PRE_CYN: b = color_byte(i, 8'h36);
            PRE_YEL: b = color_byte(i, 8'h33);
            default: b = rst_byte(i);
        endcase
        return b;
    endfunction

    function automatic logic [7:0] body_byte(input body_t bd, input logic [7:0] c,
                                             input logic [IDX_W-1:0] i);
        logic [7:0] b;
        unique case (bd)
            BODY_DOT:   b = (i == 4'd0) ? 8'hC2 : 8'hB7;
            BODY_ARROW: b = (i == 4'd0) ? 8'hE2 : ((i == 4'd1) ? 8'h86 : 8'h9C);
            default:    b = c;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/clsc_if.sv
// clsc channel interfaces: command input and colored byte output
`default_nettype none
interface clsc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] char_in;

    modport source (output valid, output operation, output char_in, input ready);
    modport sink   (input valid, input operation, input char_in, output ready);
endinterface

interface clsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/command_line_syntax_colorizer_top.sv
// command_line_syntax_colorizer_top: command-line colorizer, tokenizer plus byte sequencer
//
//   channel  dir  payload               transfer when
//   cmd      in   operation, char_in    cmd.valid && cmd.ready
//   color    out  out_byte, last_byte   color.valid && color.ready
//
// one output byte per cycle while a job is queued and the color channel is ready; an item emits 1 to 17 bytes
// the byte sequencer in clsc_back sets the rate; dropped or unused items emit nothing
// the front takes one command per cycle while the job queue has room
// rst_n clears tokenizer mode, position, queue and output valid asynchronously
// a stalled color channel holds its byte; the queue then fills and cmd.ready drops
`default_nettype none
module command_line_syntax_colorizer_top
    import clsc_pkg::*;
#(
    parameter int LINE_LENGTH = LINE_LENGTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    clsc_cmd_if.sink   cmd,
    clsc_byte_if.source color
);

    logic job_valid, job_ready, head_valid, pop;
    job_t job, head_job;

    clsc_front #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .operation (cmd.operation),
        .char_in   (cmd.char_in),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    clsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_valid),
        .push_ready (job_ready),
        .push_job   (job),
        .head_valid (head_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    clsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (color.valid),
        .out_ready  (color.ready),
        .out_byte   (color.out_byte),
        .last_byte  (color.last_byte)
    );

endmodule
`default_nettype wire

// File: rtl/clsc_front.sv
// clsc_front: tokenizer state and classification of each command transfer
`default_nettype none
module clsc_front
    import clsc_pkg::*;
#(
    parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [1:0] operation,
    input  wire  [7:0] char_in,
    output logic       job_valid,
    input  wire        job_ready,
    output job_t       job
);

    localparam int POS_W = $clog2(LINE_LENGTH + 2);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_LENGTH);

    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             has_job;
    logic             accept;

    assign in_ready  = job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = accept && has_job;

    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        has_job   = 1'b0;
        job       = '{pre: PRE_NONE, body: BODY_NONE, suf_rst: 1'b0, ch: char_in};
        case (operation)
            OP_CHAR:
            begin
                if (pos_reg <= POS_LIMIT)
                begin
                    pos_next = pos_reg + 1'b1;
                    has_job  = 1'b1;
                    job.body = BODY_CHAR;
                    unique case (mode_reg)
                        M_PLAIN:
                        begin
                            if (is_blank(char_in) && pos_reg == '0)
                            begin
                                job = '{pre: PRE_ERR, body: BODY_DOT, suf_rst: 1'b1,
                                        ch: char_in};
                            end
                            else if (char_in == CH_DASH)
                            begin
                                job.pre   = PRE_MAG;
                                mode_next = M_DASH1;
                            end
                            else if (char_in == CH_QUOTE)
                            begin
                                job.pre   = PRE_CYN;
                                mode_next = M_STRING;
                            end
                            else if (char_in == CH_DOLLAR)
                            begin
                                job.pre   = PRE_YEL;
                                mode_next = M_DOLLAR;
                            end
                        end
                        M_DASH1:
                        begin
                            if (char_in == CH_DASH)
                            begin
                                mode_next = M_DASH2;
                            end
                            else if (is_alnum(char_in))
                            begin
                                mode_next = M_OPT;
                            end
                            else
                            begin
                                job.pre     = PRE_ERR;
                                job.suf_rst = 1'b1;
                                mode_next   = M_PLAIN;
                            end
                        end
                        M_OPT:
                        begin
                            if (is_blank(char_in))
                            begin
                                job.pre   = PRE_RST;
                                mode_next = M_PLAIN;
                            end
                            else
                            begin
                                job.pre = PRE_ERR;
                            end
                        end
                        M_DASH2:
                        begin
                            if (!is_alnum(char_in))
                            begin
                                job.pre = PRE_ERR;
                            end
                            mode_next = M_TOKEN;
                        end
                        M_TOKEN:
                        begin
                            if (is_blank(char_in))
                            begin
                                job.pre   = PRE_RST;
                                mode_next = M_PLAIN;
                            end
                        end
                        M_STRING:
                        begin
                            if (char_in == CH_QUOTE)
                            begin
                                job.suf_rst = 1'b1;
                                mode_next   = M_PLAIN;
                            end
                        end
                        M_DOLLAR:
                        begin
                            if (is_alnum(char_in))
                            begin
                                mode_next = M_TOKEN;
                            end
                            else if (is_blank(char_in))
                            begin
                                job.pre     = PRE_ERR;
                                job.body    = BODY_DOT;
                                job.suf_rst = 1'b1;
                                mode_next   = M_PLAIN;
                            end
                            else
                            begin
                                job.pre   = PRE_ERR;
                                mode_next = M_TOKEN;
                            end
                        end
                        default:
                        begin
                            has_job = 1'b0;
                        end
                    endcase
                end
            end
            OP_CLEAR:
            begin
                has_job   = 1'b1;
                job.pre   = PRE_RST;
                job.body  = BODY_NONE;
                mode_next = M_PLAIN;
                pos_next  = '0;
            end
            OP_BACKERR:
            begin
                has_job     = 1'b1;
                job.pre     = PRE_ERR;
                job.body    = BODY_ARROW;
                job.suf_rst = 1'b1;
            end
            default:
            begin
                has_job = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_PLAIN;
            pos_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LIMIT + 1'b1)
        else $error("position ran past the line limit");

endmodule
`default_nettype wire

// File: rtl/clsc_queue.sv
// clsc_queue: short job queue between tokenizer and byte sequencer
`default_nettype none
module clsc_queue
    import clsc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  push,
    output logic push_ready,
    input  job_t push_job,
    output logic head_valid,
    input  wire  pop,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: rtl/clsc_back.sv
// clsc_back: walks one job's byte sequence into the output register
`default_nettype none
module clsc_back
    import clsc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [7:0] out_byte,
    output logic       last_byte
);

    seg_t             seg_reg, seg_next, seg_eff;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] plen, blen, slen, seg_len;
    logic             rest_empty, at_end, last, load;
    logic [7:0]       cur_byte;
    logic             ovalid_reg;
    logic [7:0]       obyte_reg;
    logic             olast_reg;

    assign load      = head_valid && (!ovalid_reg || out_ready);
    assign pop       = load && last;
    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign last_byte = olast_reg;

    // skip empty segments
    always_comb
    begin
        plen    = pre_len(head_job.pre);
        blen    = body_len(head_job.body);
        slen    = head_job.suf_rst ? 4'd4 : 4'd0;
        seg_eff = seg_reg;
        if (seg_eff == SEG_PRE && plen == '0)
        begin
            seg_eff = SEG_BODY;
        end
        if (seg_eff == SEG_BODY && blen == '0)
        begin
            seg_eff = SEG_SUF;
        end
    end

    // next state
    always_comb
    begin
        seg_next = seg_reg;
        idx_next = idx_reg;
        if (load)
        begin
            if (last)
            begin
                seg_next = SEG_PRE;
                idx_next = '0;
            end
            else if (at_end)
            begin
                seg_next = (seg_eff == SEG_PRE) ? SEG_BODY : SEG_SUF;
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    // outputs
    always_comb
    begin
        unique case (seg_eff)
            SEG_PRE:
            begin
                seg_len    = plen;
                rest_empty = (blen == '0) && (slen == '0);
                cur_byte   = pre_byte(head_job.pre, idx_reg);
            end
            SEG_BODY:
            begin
                seg_len    = blen;
                rest_empty = (slen == '0);
                cur_byte   = body_byte(head_job.body, head_job.ch, idx_reg);
            end
            default:
            begin
                seg_len    = slen;
                rest_empty = 1'b1;
                cur_byte   = rst_byte(idx_reg);
            end
        endcase
        at_end = (idx_reg == seg_len - 1'b1);
        last   = at_end && rest_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg    <= SEG_PRE;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            seg_reg <= seg_next;
            idx_reg <= idx_next;
            if (load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obyte_reg <= cur_byte;
            olast_reg <= last;
        end
    end

    a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (seg_reg == SEG_PRE && idx_reg == '0))
        else $error("sequencer left mid-job without a job");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < 4'd10)
        else $error("byte index out of range");

    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (ovalid_reg && olast_reg))
        else $error("job retired without a final byte");

endmodule
`default_nettype wire
